// ----- hdl/ascii_integer_parser_defines.svh -----
// Assertion macros for the parser RTL.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef ASCII_INTEGER_PARSER_DEFINES_SVH
`define ASCII_INTEGER_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AIP_ASSERT_IMPLY(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");
`define AIP_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define AIP_ASSERT_IMPLY(lbl, ck, rstn, ante, cons)
`define AIP_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

// ----- hdl/aip_pkg.sv -----
package aip_pkg;

	// Parser phases, one-hot.
	typedef enum logic [6:0] {
		PH_LEAD   = 7'b0000001,
		PH_ZERO   = 7'b0000010,
		PH_DEC    = 7'b0000100,
		PH_MINUS  = 7'b0001000,
		PH_PREFIX = 7'b0010000,
		PH_HEX    = 7'b0100000,
		PH_TRAIL  = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_BAD  = 2'd1,
		ERR_UOVF = 2'd2,
		ERR_SOVF = 2'd3
	} err_code_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_X = 8'h78;

	localparam int unsigned VALUE_W = 64;

	// Token state at its last character, before the sign is applied.
	typedef struct packed {
		logic [VALUE_W-1:0] magnitude;
		logic               negative;
		err_code_t          err;
	} pre_result_t;

endpackage

// ----- hdl/aip_step.sv -----
module aip_step
	import aip_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  character,
	input  logic        last_char,
	output pre_result_t result
);

	phase_t             phase_q, phase_n;
	logic [VALUE_W-1:0] acc_q, acc_n;
	logic               neg_q, neg_n;
	err_code_t          err_q, err_n;

	logic               is_dec, is_hexl;
	logic [3:0]         dec_digit, hex_digit;
	logic [VALUE_W+3:0] dec_sum;
	logic               dec_fits, hex_fits;

	always_comb begin
		is_dec    = character inside {[CH_ZERO:CH_NINE]};
		is_hexl   = character inside {[CH_LOW_A:CH_LOW_F]};
		dec_digit = character[3:0];
		hex_digit = character[3:0] + 4'd9;
		// acc * 10 + digit, kept wide enough to see a carry out of 64 bits.
		dec_sum   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
			+ {{VALUE_W{1'b0}}, dec_digit};
		dec_fits  = (dec_sum[VALUE_W+3:VALUE_W] == 4'd0);
		hex_fits  = (acc_q[VALUE_W-1:VALUE_W-4] == 4'd0);
	end

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		neg_n   = neg_q;
		err_n   = err_q;
		// After the first error the rest of the token is ignored.
		if (err_q == ERR_NONE) begin
			err_n = ERR_BAD;
			case (phase_q)
				PH_LEAD: begin
					if (character == CH_SPACE) begin
						err_n = ERR_NONE;
					end else if (character == CH_ZERO) begin
						err_n   = ERR_NONE;
						acc_n   = '0;
						phase_n = PH_ZERO;
					end else if (is_dec) begin
						err_n   = ERR_NONE;
						acc_n   = {{(VALUE_W-4){1'b0}}, dec_digit};
						phase_n = PH_DEC;
					end else if (character == CH_MINUS) begin
						err_n   = ERR_NONE;
						neg_n   = 1'b1;
						phase_n = PH_MINUS;
					end
				end
				PH_ZERO, PH_DEC: begin
					if (is_dec) begin
						phase_n = PH_DEC;
						if (dec_fits) begin
							err_n = ERR_NONE;
							acc_n = dec_sum[VALUE_W-1:0];
						end else begin
							err_n = ERR_UOVF;
						end
					end else if (character == CH_SPACE) begin
						err_n   = ERR_NONE;
						phase_n = PH_TRAIL;
					end else if (character == CH_LOW_X && phase_q == PH_ZERO) begin
						err_n   = ERR_NONE;
						phase_n = PH_PREFIX;
					end
				end
				PH_MINUS: begin
					if (character == CH_ZERO) begin
						err_n   = ERR_NONE;
						phase_n = PH_ZERO;
					end else if (is_dec) begin
						err_n   = ERR_NONE;
						acc_n   = {{(VALUE_W-4){1'b0}}, dec_digit};
						phase_n = PH_DEC;
					end
				end
				PH_PREFIX, PH_HEX: begin
					if (is_dec || is_hexl) begin
						phase_n = PH_HEX;
						if (hex_fits) begin
							err_n = ERR_NONE;
							acc_n = {acc_q[VALUE_W-5:0], (is_dec ? dec_digit : hex_digit)};
						end else begin
							err_n = ERR_UOVF;
						end
					end
				end
				PH_TRAIL: begin
					if (character == CH_SPACE) begin
						err_n = ERR_NONE;
					end
				end
				default: begin
					err_n = ERR_BAD;
				end
			endcase
		end
	end

	assign result = '{magnitude: acc_n, negative: neg_n, err: err_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			err_q   <= ERR_NONE;
		end else if (en) begin
			if (last_char) begin
				phase_q <= PH_LEAD;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				err_q   <= ERR_NONE;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

// ----- hdl/aip_finish.sv -----
module aip_finish
	import aip_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  pre_result_t         in_result,
	output logic                in_ready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [VALUE_W+7:0]  m_tdata
);

	logic [VALUE_W-1:0] value_c;
	err_code_t          err_c;
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	err_code_t          err_q;

	// Apply the sign; a negative magnitude needs bit 63 clear to fit.
	always_comb begin
		err_c   = in_result.err;
		value_c = in_result.magnitude;
		if (err_c == ERR_NONE && in_result.negative) begin
			if (in_result.magnitude[VALUE_W-1]) begin
				err_c = ERR_SOVF;
			end else begin
				value_c = ~in_result.magnitude + {{(VALUE_W-1){1'b0}}, 1'b1};
			end
		end
		if (err_c != ERR_NONE) begin
			value_c = '0;
		end
	end

	assign in_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			value_q <= value_c;
			err_q   <= err_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b000000, err_q, value_q};

endmodule

// ----- hdl/ascii_integer_parser.sv -----
// Channel   Direction  Payload
// s_*       in         tdata[7:0] character, tlast = last character of the token
// m_*       out        tdata[63:0] value, tdata[65:64] error code, tdata[71:66] zero
//
// One character item is taken per cycle while s_tready is high; after its last character
// is taken, a token's result moves through the input register, sign stage and output register.
// The per-character step is one shift-add and compare on the 64-bit accumulator.
// Reset clears the parser state and empties all stages; no clearing pass is needed.
// A stall on the result side only holds the input once a last character has to wait,
// since characters that end no token never occupy the result stages.
`include "ascii_integer_parser_defines.svh"

module ascii_integer_parser
	import aip_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] character
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W+7:0] m_tdata    // [63:0] value, [65:64] error_code, zero fill
);

	// Input register: one character with its last-of-token flag.
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;

	// Sign stage: the token state as it stood after its last character.
	logic        valid_s2;
	pre_result_t res_s2;

	pre_result_t step_result;
	logic        step_en;
	logic        adv_s1;
	logic        s2_ready;
	logic        out_ready;

	// A character that ends no token only updates the parser state, so it moves on even
	// when the result side is stalled. A last character needs room in the sign stage.
	assign s2_ready = !valid_s2 || out_ready;
	assign adv_s1   = !last_s1 || s2_ready;
	assign s_tready = !valid_s1 || adv_s1;
	assign step_en  = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	aip_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (step_en),
		.character (char_s1),
		.last_char (last_s1),
		.result    (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= step_en && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && step_en && last_s1) begin
			res_s2 <= step_result;
		end
	end

	aip_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_result (res_s2),
		.in_ready  (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Any error forces the value to zero.
	`AIP_ASSERT_IMPLY(a_err_zero_value, clk, arst_n,
		m_tvalid && (m_tdata[VALUE_W+1:VALUE_W] != ERR_NONE), m_tdata[VALUE_W-1:0] == '0)
	// With the output register empty, nothing downstream can hold the input back.
	`AIP_ASSERT_IMPLY(a_ready_when_drained, clk, arst_n, !m_tvalid, s_tready)
	// A result waiting in the sign stage is neither lost nor changed while blocked.
	`AIP_ASSERT_NEXT(a_s2_holds, clk, arst_n, valid_s2 && !out_ready,
		valid_s2 && $stable(res_s2))
	// Only a last character can be held in the input register.
	`AIP_ASSERT_IMPLY(a_only_last_waits, clk, arst_n, valid_s1 && !adv_s1, last_s1)

endmodule

// ----- tb/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import aip_pkg::*;

	// One parsed number as it should leave the result channel.
	typedef struct {
		logic [VALUE_W-1:0] value;
		err_code_t          code;
	} number_t;

	// Tracks the parser state from the accepted characters and keeps the numbers
	// that the parser still owes, oldest first.
	class token_checker;
		phase_t             phase;
		logic [VALUE_W-1:0] accum;
		logic               minus;
		err_code_t          pend;
		number_t            expected_numbers[$];
		int unsigned        mismatches;

		function new();
			clear();
			mismatches = 0;
		endfunction

		function void clear();
			phase = PH_LEAD;
			accum = '0;
			minus = 1'b0;
			pend  = ERR_NONE;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		function int unsigned pending();
			return expected_numbers.size();
		endfunction

		// Advances the parser state by one accepted character and, on the last
		// character of a token, queues the number the token should produce.
		function void note_char(logic [7:0] c, logic last);
			logic               is_digit;
			logic               is_hex_letter;
			logic               bad;
			logic               grow_dec;
			logic               grow_hex;
			logic [VALUE_W-1:0] digit;
			number_t            n;

			is_digit      = (c >= CH_ZERO) && (c <= CH_NINE);
			is_hex_letter = (c >= CH_LOW_A) && (c <= CH_LOW_F);
			digit         = is_digit ? VALUE_W'(c - CH_ZERO) : VALUE_W'(c - CH_LOW_A) + 10;
			bad           = 1'b0;
			grow_dec      = 1'b0;
			grow_hex      = 1'b0;

			// Once an error is pending the rest of the token is ignored.
			if (pend == ERR_NONE) begin
				case (phase)
					PH_LEAD: begin
						if (c == CH_ZERO) begin
							accum = '0;
							phase = PH_ZERO;
						end else if (is_digit) begin
							accum = digit;
							phase = PH_DEC;
						end else if (c == CH_MINUS) begin
							minus = 1'b1;
							phase = PH_MINUS;
						end else if (c != CH_SPACE) begin
							bad = 1'b1;
						end
					end
					PH_ZERO: begin
						if (is_digit) begin
							phase    = PH_DEC;
							grow_dec = 1'b1;
						end else if (c == CH_LOW_X) begin
							phase = PH_PREFIX;
						end else if (c == CH_SPACE) begin
							phase = PH_TRAIL;
						end else begin
							bad = 1'b1;
						end
					end
					PH_DEC: begin
						if (is_digit)
							grow_dec = 1'b1;
						else if (c == CH_SPACE)
							phase = PH_TRAIL;
						else
							bad = 1'b1;
					end
					PH_MINUS: begin
						if (c == CH_ZERO) begin
							phase = PH_ZERO;
						end else if (is_digit) begin
							accum = digit;
							phase = PH_DEC;
						end else begin
							bad = 1'b1;
						end
					end
					PH_PREFIX, PH_HEX: begin
						if (is_digit || is_hex_letter) begin
							phase    = PH_HEX;
							grow_hex = 1'b1;
						end else begin
							bad = 1'b1;
						end
					end
					PH_TRAIL: begin
						if (c != CH_SPACE)
							bad = 1'b1;
					end
					default: bad = 1'b1;
				endcase

				// Overflow is caught before the accumulator would wrap.
				if (bad) begin
					pend = ERR_BAD;
				end else if (grow_dec) begin
					if (accum > ({VALUE_W{1'b1}} - digit) / 10)
						pend = ERR_UOVF;
					else
						accum = accum * 10 + digit;
				end else if (grow_hex) begin
					if (accum[VALUE_W-1:VALUE_W-4] != 4'd0)
						pend = ERR_UOVF;
					else
						accum = {accum[VALUE_W-5:0], digit[3:0]};
				end
			end

			if (!last)
				return;

			n.code  = pend;
			n.value = accum;
			if (pend == ERR_NONE && minus) begin
				if (accum[VALUE_W-1])
					n.code = ERR_SOVF;
				else
					n.value = -accum;
			end
			if (n.code != ERR_NONE)
				n.value = '0;
			expected_numbers.push_back(n);
			clear();
		endfunction

		task check_number(logic [VALUE_W+7:0] data);
			number_t n;

			if (expected_numbers.size() == 0) begin
				report($sformatf("result with nothing expected: value=%h code=%0d",
					data[VALUE_W-1:0], data[VALUE_W+1:VALUE_W]));
				return;
			end
			n = expected_numbers.pop_front();
			if (data[VALUE_W-1:0] !== n.value)
				report($sformatf("value %h, expected %h", data[VALUE_W-1:0], n.value));
			if (data[VALUE_W+1:VALUE_W] !== n.code)
				report($sformatf("error code %0d, expected %0d",
					data[VALUE_W+1:VALUE_W], n.code));
			if (data[VALUE_W+7:VALUE_W+2] !== '0)
				report($sformatf("fill bits %b, expected zero", data[VALUE_W+7:VALUE_W+2]));
		endtask
	endclass

	// Receiver stall patterns. Each one runs for a segment of random length.
	typedef enum logic [1:0] {
		RX_STEADY,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE
	} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [VALUE_W+7:0] m_tdata;

	token_checker sb = new();

	// Characters of the token being built, and the sender's burst bookkeeping.
	logic [7:0]  chars[$];
	int          burst_left = 0;
	int unsigned chars_sent = 0;
	bit          random_phase = 1'b0;
	bit          held_off = 1'b0;

	// Magnitudes around the points where the decimal check and the sign check trip.
	logic [VALUE_W-1:0] boundary_values [0:7] = '{
		64'hFFFF_FFFF_FFFF_FFFF,
		64'hFFFF_FFFF_FFFF_FFFA,
		64'h8000_0000_0000_0000,
		64'h8000_0000_0000_0001,
		64'h7FFF_FFFF_FFFF_FFFF,
		64'd1844674407370955161,
		64'd1844674407370955162,
		64'd0
	};

	ascii_integer_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	// Both channels are observed at the rising edge, where the handshake counts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				sb.check_number(m_tdata);
		end
	end

	function void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			chars.push_back(s[i]);
	endfunction

	function automatic void append_decimal(logic [VALUE_W-1:0] v);
		logic [7:0] digits[$];

		do begin
			digits.push_front(8'(CH_ZERO + v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digits[i])
			chars.push_back(digits[i]);
	endfunction

	// Builds a well-formed decimal or hex token with random content: optional
	// leading spaces and sign, values near the overflow points, long digit runs.
	task automatic make_number_token(bit hex);
		int ndig;
		int d;

		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
			chars.push_back(CH_SPACE);
		if ($urandom_range(0, 2) == 0)
			chars.push_back(CH_MINUS);
		if (hex) begin
			push_text("0x");
			// Sixteen digits fill the accumulator; a seventeenth overflows it
			// unless the run starts with zeros.
			ndig = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : $urandom_range(13, 17);
			repeat (ndig) begin
				d = $urandom_range(0, 15);
				chars.push_back((d < 10) ? 8'(CH_ZERO + d) : 8'(CH_LOW_A + d - 10));
			end
		end else begin
			if ($urandom_range(0, 5) == 0)
				chars.push_back(CH_ZERO);
			case ($urandom_range(0, 3))
				0: append_decimal(VALUE_W'($urandom_range(0, 999)));
				1: append_decimal({$urandom, $urandom} >> $urandom_range(0, 63));
				2: append_decimal(boundary_values[$urandom_range(0, 7)]);
				default: begin
					// Twenty digits just around the largest magnitude, sometimes
					// one digit longer, so that both sides of the limit appear.
					append_decimal(64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 20));
					chars[chars.size() - 1] = 8'(CH_ZERO + $urandom_range(0, 9));
					if ($urandom_range(0, 1) == 1)
						chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
				end
			endcase
			repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0)
				chars.push_back(CH_SPACE);
		end
	endtask

	// Sends the queued token, marking its final character, in bursts of random
	// length with idle gaps between them. Called just after a falling edge.
	task automatic send_token();
		int gap;

		for (int i = 0; i < chars.size(); i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			s_tvalid <= 1'b1;
			s_tdata  <= chars[i];
			s_tlast  <= (i == chars.size() - 1);
			do
				@(posedge clk);
			while (!s_tready);
			@(negedge clk);
			burst_left--;
			chars_sent++;
		end
		chars.delete();
	endtask

	// Stimulus: reset, a short directed set of tokens, then random tokens, then drain.
	initial begin
		string directed[] = '{"0", "-0", "-", " ", "0x", " -9 ", "0xf", "0x1 ", "5x", "0xAB"};
		int    kind;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Tokens that end early, minus zero, a trailing space after hex digits,
		// an upper-case hex digit and errors followed by ignored characters.
		foreach (directed[k]) begin
			push_text(directed[k]);
			send_token();
		end
		// Characters at both ends of the byte range, each a whole token.
		chars.push_back(8'hFF);
		send_token();
		chars.push_back(8'h00);
		send_token();

		random_phase = 1'b1;
		chars_sent   = 0;
		while (chars_sent < 900) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				make_number_token(1'b0);
			end else if (kind < 60) begin
				make_number_token(1'b1);
			end else if (kind < 85) begin
				// A well-formed token with one character replaced by any byte.
				make_number_token(1'($urandom_range(0, 1)));
				chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
			end else if (kind < 93) begin
				// Tokens that stop after spaces, a sign, a lone zero or the prefix.
				repeat ($urandom_range(0, 2))
					chars.push_back(CH_SPACE);
				if ($urandom_range(0, 1) == 1)
					chars.push_back(CH_MINUS);
				case ($urandom_range(0, 3))
					1: chars.push_back(CH_ZERO);
					2: push_text("0x");
					3: push_text("0 ");
					default: ;
				endcase
				if (chars.size() == 0)
					chars.push_back(CH_SPACE);
			end else begin
				repeat ($urandom_range(1, 6))
					chars.push_back(8'($urandom_range(0, 255)));
			end
			send_token();
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		// Every token ended with a flagged character, so each owes a result.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Receiver: segments of steady, light, heavy or alternating stalls. Once the
	// random part starts it holds off for a long stretch while characters keep
	// coming, so the result stages fill and the input side has to stall.
	initial begin
		rx_mode_t mode;
		int       seg_left;

		m_tready = 1'b0;
		mode     = RX_STEADY;
		seg_left = 0;
		forever begin
			@(negedge clk);
			if (random_phase && !held_off) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
			end else begin
				if (seg_left == 0) begin
					mode     = rx_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(10, 120);
				end
				seg_left--;
				case (mode)
					RX_STEADY: m_tready <= 1'b1;
					RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
					RX_HEAVY:  m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ~m_tready;
				endcase
			end
		end
	end

	// Watchdog, far above the slowest correct run.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
